FILE: design/three_channel_sample_median_macros.svh
// Assertion macros for the three-channel sample median block.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef THREE_CHANNEL_SAMPLE_MEDIAN_MACROS_SVH
`define THREE_CHANNEL_SAMPLE_MEDIAN_MACROS_SVH

// same-cycle implication
`define TCSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tcsm_pkg.sv
// Package for the three-channel sample median block: constants, beat types,
// sequencer states and the control struct of the shared accumulate unit.
`default_nettype none
package tcsm_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int NUM_CH      = 3;
  localparam int BIN_W       = 8;
  localparam int BINS        = 1 << BIN_W;
  localparam int CH_W        = 2;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int MEM_DEPTH   = NUM_CH * BINS;
  localparam int ADDR_W      = CH_W + BIN_W;

  localparam logic [CH_W-1:0]  CH_BLUE  = 2'd0;
  localparam logic [CH_W-1:0]  CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0]  CH_RED   = 2'd2;
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] median_blue;
    logic [7:0] median_green;
    logic [7:0] median_red;
    logic       overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc;    // accumulate running sum, else increment a bin
    logic first;  // first bin of a channel: running sum restarts
  } acc_ctl_t;

endpackage
`default_nettype wire

FILE: design/tcsm_ram.sv
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module tcsm_ram #(
  parameter int DEPTH = 768,
  parameter int DW    = 9,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/tcsm_acc.sv
// Shared add/compare unit: bin increment during histogram update,
// running-sum accumulate and rank compare during the median scan. Uses tcsm_pkg.
`default_nettype none
module tcsm_acc (
  input  wire logic                      clk,
  input  wire tcsm_pkg::acc_ctl_t        ctl,
  input  wire logic [tcsm_pkg::CNT_W-1:0] rdata,
  input  wire logic [tcsm_pkg::CNT_W-1:0] target,
  output logic      [tcsm_pkg::CNT_W-1:0] sum,
  output logic                            hit
);

  logic [tcsm_pkg::CNT_W-1:0] sum_r;
  logic [tcsm_pkg::CNT_W-1:0] opa;

  always_comb begin
    if (!ctl.acc) begin
      opa = tcsm_pkg::CNT_W'(1);
    end else if (ctl.first) begin
      opa = '0;
    end else begin
      opa = sum_r;
    end
  end

  assign sum = opa + rdata;
  assign hit = sum > target;

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      sum_r <= sum;
    end
  end

endmodule
`default_nettype wire

FILE: design/three_channel_sample_median.sv
// Three-channel sample median: top level with sequencer, histogram RAM and
// shared unit. Uses tcsm_pkg, tcsm_ram, tcsm_acc and the assertion macros.
//
// Usage:
//   in_valid/in_ready/in_data carry one color sample per beat (blue, green,
//   red, last). out_valid/out_ready/out_data carry one result per run: the
//   per-channel value at sorted index count/2 and an overflow flag.
//   Histograms of all three channels live in one 768-entry RAM.
//   A kept sample is accepted, then read and written once per channel through
//   the single RAM port pair. A sample past MAX_SAMPLES is dropped, and the
//   block stays ready unless that sample is the last of its run.
//   After a last-marked sample the scan reads and clears every bin, one per
//   cycle; a drain state follows, then the result is loaded into the output
//   register.
//   After reset a clearing pass over every bin runs with in_ready low.
//   The output register holds a result until taken; a stalled receiver
//   stalls the block only when the next result is ready to load.
`default_nettype none
`include "three_channel_sample_median_macros.svh"
module three_channel_sample_median (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tcsm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tcsm_pkg::out_t      out_data
);

  localparam int CNT_W = tcsm_pkg::CNT_W;
  localparam int CH_W  = tcsm_pkg::CH_W;
  localparam int BIN_W = tcsm_pkg::BIN_W;

  tcsm_pkg::state_t state_r, state_nxt;

  tcsm_pkg::in_t      smp_r;
  tcsm_pkg::out_t     out_r;
  logic               out_valid_r;
  logic [CH_W-1:0]    ch_r;
  logic [BIN_W-1:0]   bin_r;
  logic [CH_W-1:0]    d_ch_r;
  logic [BIN_W-1:0]   d_bin_r;
  logic               scan_v_r;
  logic [CNT_W-1:0]   count_r;
  logic               drop_r;
  logic [2:0]         found_r;
  logic [BIN_W-1:0]   med_r [3];

  logic                       in_fire;
  logic                       kept;
  logic                       last_pos;
  logic                       out_load;
  logic                       ram_we;
  logic [BIN_W-1:0]           bin_sel;
  logic [BIN_W-1:0]           smp_val;
  logic [tcsm_pkg::ADDR_W-1:0] addr;
  logic [CNT_W-1:0]           ram_wdata;
  logic [CNT_W-1:0]           ram_rdata;
  logic [CNT_W-1:0]           target;
  logic [CNT_W-1:0]           sum;
  logic                       hit;
  tcsm_pkg::acc_ctl_t         acc_ctl;

  assign in_fire  = in_valid && in_ready;
  assign kept     = count_r < CNT_W'(tcsm_pkg::MAX_SAMPLES);
  assign last_pos = (ch_r == tcsm_pkg::CH_RED) && (bin_r == tcsm_pkg::BIN_LAST);
  assign out_load = (state_r == tcsm_pkg::ST_OUT) && (!out_valid_r || out_ready);
  assign target   = {1'b0, count_r[CNT_W-1:1]};
  assign addr     = {ch_r, bin_sel};

  always_comb begin
    case (ch_r)
      tcsm_pkg::CH_BLUE:  smp_val = smp_r.blue;
      tcsm_pkg::CH_GREEN: smp_val = smp_r.green;
      default:            smp_val = smp_r.red;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcsm_pkg::ST_CLEAR: begin
        if (last_pos) state_nxt = tcsm_pkg::ST_IDLE;
      end
      tcsm_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (kept) state_nxt = tcsm_pkg::ST_RD;
          else if (in_data.last) state_nxt = tcsm_pkg::ST_SCAN;
        end
      end
      tcsm_pkg::ST_RD: state_nxt = tcsm_pkg::ST_WR;
      tcsm_pkg::ST_WR: begin
        if (ch_r != tcsm_pkg::CH_RED) state_nxt = tcsm_pkg::ST_RD;
        else if (smp_r.last) state_nxt = tcsm_pkg::ST_SCAN;
        else state_nxt = tcsm_pkg::ST_IDLE;
      end
      tcsm_pkg::ST_SCAN: begin
        if (last_pos) state_nxt = tcsm_pkg::ST_DRAIN;
      end
      tcsm_pkg::ST_DRAIN: state_nxt = tcsm_pkg::ST_OUT;
      tcsm_pkg::ST_OUT: begin
        if (out_load) state_nxt = tcsm_pkg::ST_IDLE;
      end
      default: state_nxt = tcsm_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = '0;
    bin_sel   = bin_r;
    case (state_r)
      tcsm_pkg::ST_CLEAR: ram_we = 1'b1;
      tcsm_pkg::ST_IDLE:  in_ready = 1'b1;
      tcsm_pkg::ST_RD:    bin_sel = smp_val;
      tcsm_pkg::ST_WR: begin
        bin_sel   = smp_val;
        ram_we    = 1'b1;
        ram_wdata = sum;
      end
      tcsm_pkg::ST_SCAN:  ram_we = 1'b1;
      default: begin
      end
    endcase
  end

  assign acc_ctl.acc   = scan_v_r;
  assign acc_ctl.first = d_bin_r == '0;

  tcsm_ram #(
    .DEPTH (tcsm_pkg::MEM_DEPTH),
    .DW    (CNT_W),
    .AW    (tcsm_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  tcsm_acc u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .rdata  (ram_rdata),
    .target (target),
    .sum    (sum),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcsm_pkg::ST_CLEAR;
      ch_r        <= '0;
      bin_r       <= '0;
      count_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      scan_v_r    <= 1'b0;
      found_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      scan_v_r <= state_r == tcsm_pkg::ST_SCAN;
      if (in_fire) begin
        if (kept) count_r <= count_r + CNT_W'(1);
        else drop_r <= 1'b1;
      end
      case (state_r)
        tcsm_pkg::ST_CLEAR, tcsm_pkg::ST_SCAN: begin
          if (bin_r == tcsm_pkg::BIN_LAST) begin
            bin_r <= '0;
            ch_r  <= last_pos ? tcsm_pkg::CH_BLUE : ch_r + CH_W'(1);
          end else begin
            bin_r <= bin_r + BIN_W'(1);
          end
        end
        tcsm_pkg::ST_IDLE: ch_r <= tcsm_pkg::CH_BLUE;
        tcsm_pkg::ST_WR: begin
          ch_r <= (ch_r == tcsm_pkg::CH_RED) ? tcsm_pkg::CH_BLUE : ch_r + CH_W'(1);
        end
        default: begin
        end
      endcase
      if (state_r != tcsm_pkg::ST_SCAN && state_r != tcsm_pkg::ST_DRAIN) begin
        found_r <= '0;
      end else if (scan_v_r && hit && !found_r[d_ch_r]) begin
        found_r[d_ch_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        count_r     <= '0;
        drop_r      <= 1'b0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) smp_r <= in_data;
    d_ch_r  <= ch_r;
    d_bin_r <= bin_r;
    if (state_r == tcsm_pkg::ST_IDLE) begin
      med_r[0] <= '0;
      med_r[1] <= '0;
      med_r[2] <= '0;
    end else if (scan_v_r && hit && !found_r[d_ch_r]) begin
      med_r[d_ch_r] <= d_bin_r;
    end
    if (out_load) begin
      out_r.median_blue  <= med_r[0];
      out_r.median_green <= med_r[1];
      out_r.median_red   <= med_r[2];
      out_r.overflow     <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TCSM_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(tcsm_pkg::MAX_SAMPLES),
    "sample count past maximum")
  `TCSM_ASSERT_NXT(a_drop_flag, in_fire && !kept, drop_r,
    "dropped sample not flagged")
  `TCSM_ASSERT_NXT(a_busy_update, in_fire && kept, !in_ready,
    "ready during histogram update")
  `TCSM_ASSERT_NXT(a_out_load, out_load, out_valid_r && count_r == '0 && !drop_r,
    "result load did not close the run")

endmodule
`default_nettype wire

FILE: sim/tb_three_channel_sample_median.sv
`timescale 1ns / 100ps
// Self-checking testbench for three_channel_sample_median: drives sample runs,
// predicts the per-channel upper medians and compares every result beat.
// Depends on tcsm_pkg and the three_channel_sample_median RTL only.
module tb_three_channel_sample_median;

  typedef enum int {FILL_RANDOM, FILL_CLUSTER, FILL_CONST, FILL_EXTREME} fill_t;

  localparam int SCAN_WAIT = 800;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tcsm_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  tcsm_pkg::out_t out_data;

  int unsigned    bin_counts [tcsm_pkg::NUM_CH][tcsm_pkg::BINS];
  int unsigned    run_count;
  bit             run_dropped;
  tcsm_pkg::out_t expected_medians [$];

  int src_idle_pct;
  int snk_stall_pct;
  int hold_cycles;
  int errors;
  int samples_sent;
  int runs_sent;
  int overflow_runs;
  int results_seen;

  three_channel_sample_median u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Timeout at %0t", $time);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] value_at_rank(input int ch, input int unsigned rank);
    int unsigned sum = 0;
    for (int b = 0; b < tcsm_pkg::BINS; b++) begin
      sum += bin_counts[ch][b];
      if (sum > rank) return 8'(b);
    end
    return 8'd0;
  endfunction

  task automatic clear_histograms();
    foreach (bin_counts[c, b]) bin_counts[c][b] = 0;
    run_count   = 0;
    run_dropped = 1'b0;
  endtask

  task automatic predict_sample(input tcsm_pkg::in_t s);
    tcsm_pkg::out_t r;
    int unsigned mid;
    if (run_count < tcsm_pkg::MAX_SAMPLES) begin
      bin_counts[tcsm_pkg::CH_BLUE][s.blue]++;
      bin_counts[tcsm_pkg::CH_GREEN][s.green]++;
      bin_counts[tcsm_pkg::CH_RED][s.red]++;
      run_count++;
    end else begin
      run_dropped = 1'b1;
    end
    if (s.last) begin
      mid            = run_count / 2;
      r.median_blue  = value_at_rank(tcsm_pkg::CH_BLUE, mid);
      r.median_green = value_at_rank(tcsm_pkg::CH_GREEN, mid);
      r.median_red   = value_at_rank(tcsm_pkg::CH_RED, mid);
      r.overflow     = run_dropped;
      expected_medians.push_back(r);
      runs_sent++;
      if (run_dropped) overflow_runs++;
      clear_histograms();
    end
  endtask

  // one input beat; valid stays high after acceptance until the next call or idle
  task automatic send_sample(input tcsm_pkg::in_t s);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    predict_sample(s);
  endtask

  task automatic send_bgr(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                          input logic last);
    tcsm_pkg::in_t s;
    s.blue  = b;
    s.green = g;
    s.red   = r;
    s.last  = last;
    send_sample(s);
  endtask

  function automatic logic [7:0] fill_value(input fill_t mode, input logic [7:0] base);
    case (mode)
      FILL_CLUSTER: return base + 8'($urandom_range(7));
      FILL_CONST:   return base;
      FILL_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
      default:      return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_run(input int len, input fill_t mode);
    logic [7:0] bb, gb, rb;
    bb = 8'($urandom_range(255));
    gb = 8'($urandom_range(255));
    rb = 8'($urandom_range(255));
    for (int i = 0; i < len; i++) begin
      send_bgr(fill_value(mode, bb), fill_value(mode, gb), fill_value(mode, rb),
               i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_medians.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    tcsm_pkg::out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (expected_medians.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
          errors++;
        end else begin
          want = expected_medians.pop_front();
          check_field("median_blue", want.median_blue, out_data.median_blue);
          check_field("median_green", want.median_green, out_data.median_green);
          check_field("median_red", want.median_red, out_data.median_red);
          check_field("overflow", 8'(want.overflow), 8'(out_data.overflow));
        end
      end
    end
  end

  task automatic test_single_sample();
    send_bgr(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_bgr(8'h00, 8'h00, 8'h00, 1'b1);
    send_bgr(8'hAA, 8'h55, 8'h0F, 1'b1);
    send_bgr(8'h01, 8'h80, 8'hFE, 1'b1);
    wait_drained();
  endtask

  task automatic test_even_count();
    send_bgr(8'd10, 8'd200, 8'd0, 1'b0);
    send_bgr(8'd20, 8'd100, 8'd255, 1'b1);
    send_bgr(8'd7, 8'd7, 8'd9, 1'b0);
    send_bgr(8'd3, 8'd7, 8'd1, 1'b0);
    send_bgr(8'd7, 8'd2, 8'd9, 1'b0);
    send_bgr(8'd3, 8'd2, 8'd1, 1'b1);
    wait_drained();
  endtask

  task automatic test_extreme_values();
    send_bgr(8'h00, 8'hFF, 8'h00, 1'b0);
    send_bgr(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_bgr(8'h00, 8'hFF, 8'hFF, 1'b0);
    send_bgr(8'hFF, 8'h00, 8'h00, 1'b0);
    send_bgr(8'hFF, 8'hFF, 8'h00, 1'b1);
    send_run(6, FILL_CONST);
    send_run(5, FILL_EXTREME);
    wait_drained();
  endtask

  // exactly full, last dropped, many dropped, then a clean run
  task automatic test_full_run();
    send_run(tcsm_pkg::MAX_SAMPLES, FILL_RANDOM);
    send_run(tcsm_pkg::MAX_SAMPLES + 1, FILL_CLUSTER);
    send_run(tcsm_pkg::MAX_SAMPLES + 20, FILL_RANDOM);
    send_bgr(8'h42, 8'h24, 8'h99, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_cycles   = 4000;
    for (int i = 0; i < 4; i++) send_run($urandom_range(2, 6), FILL_RANDOM);
    wait_drained();
  endtask

  task automatic random_phase(input int src_pct, input int snk_pct, input int n_items);
    int pick;
    int len;
    int stop_at;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    stop_at       = samples_sent + n_items;
    while (samples_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(1, 16);
      else if (pick < 93) len = $urandom_range(17, 64);
      else if (pick < 98) len = $urandom_range(65, tcsm_pkg::MAX_SAMPLES - 1);
      else len = $urandom_range(tcsm_pkg::MAX_SAMPLES, tcsm_pkg::MAX_SAMPLES + 12);
      send_run(len, fill_t'($urandom_range(3)));
    end
    wait_drained();
  endtask

  task automatic test_random_runs();
    random_phase(0, 0, 180);
    random_phase(74, 0, 180);
    random_phase(0, 74, 180);
    random_phase(37, 37, 180);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_cycles   = 0;
    errors        = 0;
    samples_sent  = 0;
    runs_sent     = 0;
    overflow_runs = 0;
    results_seen  = 0;
    clear_histograms();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_single_sample();
    test_even_count();
    test_extreme_values();
    test_full_run();
    test_backpressure();
    test_random_runs();

    repeat (SCAN_WAIT) @(posedge clk);
    $display("Sent %0d samples in %0d runs (%0d overflowed), checked %0d result beats,",
             samples_sent, runs_sent, overflow_runs, results_seen);
    $display("across four idle/stall mixes and one long output hold-off.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
